FILE: hw/rtl/box_slide_axis_blocker_unit_assert.svh
// assertion macros for the box slide axis blocker
`ifndef BOX_SLIDE_AXIS_BLOCKER_UNIT_ASSERT_SVH
`define BOX_SLIDE_AXIS_BLOCKER_UNIT_ASSERT_SVH

// property holds at every clock edge outside reset
`define BSAB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bsab assertion failed");

// consequent holds in the cycle after the antecedent
`define BSAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsab assertion failed");

`endif

FILE: hw/rtl/bsab_pkg.sv
// shared types, side codes and helpers for the box slide axis blocker
package bsab_pkg;

  localparam int unsigned CoordW = 16;

  typedef logic signed [CoordW-1:0] coord_t;

  // side codes, ored over both axes
  typedef logic [3:0] side_t;
  localparam side_t SideNone = 4'd0;
  localparam side_t SideZlo  = 4'd1;
  localparam side_t SideZhi  = 4'd2;
  localparam side_t SideXlo  = 4'd4;
  localparam side_t SideXhi  = 4'd8;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_EDGE,
    KIND_CORNER
  } kind_e;

  typedef struct packed {
    coord_t start_x1;
    coord_t start_x2;
    coord_t start_z1;
    coord_t start_z2;
    coord_t moved_x1;
    coord_t moved_x2;
    coord_t moved_z1;
    coord_t moved_z2;
    coord_t obstacle_x1;
    coord_t obstacle_x2;
    coord_t obstacle_z1;
    coord_t obstacle_z2;
  } boxes_t;

  typedef struct packed {
    logic zero_dx;
    logic zero_dz;
  } flags_t;

  function automatic kind_e code_kind(side_t c);
    kind_e k;
    if (c == (SideXlo | SideZlo) || c == (SideXhi | SideZlo) ||
        c == (SideXlo | SideZhi) || c == (SideXhi | SideZhi)) begin
      k = KIND_CORNER;
    end else if (c != SideNone) begin
      k = KIND_EDGE;
    end else begin
      k = KIND_NONE;
    end
    return k;
  endfunction

  // a single-axis code cancels the matching delta, anything else nothing
  function automatic flags_t axis_cancel(side_t c);
    flags_t f;
    f = '0;
    if (c == SideZlo || c == SideZhi) begin
      f.zero_dz = 1'b1;
    end else if (c == SideXlo || c == SideXhi) begin
      f.zero_dx = 1'b1;
    end
    return f;
  endfunction

endpackage

FILE: hw/rtl/bsab_decide.sv
// side classification and cancel decision for one box triple
module bsab_decide (
  input  bsab_pkg::boxes_t boxes_i,
  output bsab_pkg::flags_t flags_o
);
  import bsab_pkg::*;

  side_t               sc;
  side_t               oc;
  kind_e               sk;
  kind_e               ok;
  logic signed [16:0]  sum_x;
  logic signed [16:0]  sum_z;
  logic signed [16:0]  half_x;
  logic signed [16:0]  half_z;
  coord_t              cx;
  coord_t              cz;
  logic signed [16:0]  dx;
  logic signed [16:0]  dz;
  logic        [16:0]  mag_x;
  logic        [16:0]  mag_z;

  // centre of the moved box, halved toward zero
  assign sum_x  = $signed({boxes_i.moved_x1[15], boxes_i.moved_x1})
                + $signed({boxes_i.moved_x2[15], boxes_i.moved_x2});
  assign sum_z  = $signed({boxes_i.moved_z1[15], boxes_i.moved_z1})
                + $signed({boxes_i.moved_z2[15], boxes_i.moved_z2});
  assign half_x = (sum_x + $signed({16'd0, sum_x[16] & sum_x[0]})) >>> 1;
  assign half_z = (sum_z + $signed({16'd0, sum_z[16] & sum_z[0]})) >>> 1;
  assign cx     = half_x[15:0];
  assign cz     = half_z[15:0];

  assign dx     = $signed({boxes_i.moved_x1[15], boxes_i.moved_x1})
                - $signed({boxes_i.start_x1[15], boxes_i.start_x1});
  assign dz     = $signed({boxes_i.moved_z1[15], boxes_i.moved_z1})
                - $signed({boxes_i.start_z1[15], boxes_i.start_z1});
  assign mag_x  = dx[16] ? 17'(-dx) : 17'(dx);
  assign mag_z  = dz[16] ? 17'(-dz) : 17'(dz);

  always_comb begin
    sc = SideNone;
    if (boxes_i.start_x2 > boxes_i.obstacle_x1) begin
      if (boxes_i.obstacle_x2 <= boxes_i.start_x1) begin
        sc = SideXhi;
      end
    end else begin
      sc = SideXlo;
    end
    if (boxes_i.start_z2 > boxes_i.obstacle_z1) begin
      if (boxes_i.start_z1 >= boxes_i.obstacle_z2) begin
        sc = sc | SideZhi;
      end
    end else begin
      sc = sc | SideZlo;
    end

    if (boxes_i.obstacle_x1 > cx) begin
      oc = SideXlo;
    end else if (boxes_i.obstacle_x2 < cx) begin
      oc = SideNone;
    end else begin
      oc = SideXhi;
    end
    if (boxes_i.obstacle_z1 > cz) begin
      oc = oc | SideZlo;
    end else if (!(boxes_i.obstacle_z2 < cz)) begin
      oc = oc | SideZhi;
    end

    sk = code_kind(sc);
    ok = code_kind(oc);

    flags_o = '0;
    priority if (sk == KIND_NONE) begin
      flags_o = '{zero_dx: 1'b1, zero_dz: 1'b1};
    end else if (sk == KIND_EDGE) begin
      flags_o = axis_cancel(sc);
    end else if (ok == KIND_EDGE && (oc & sc) != SideNone) begin
      flags_o = axis_cancel(oc);
    end else if (oc == sc) begin
      // corner on both: cancel along the axis that moved less, x on a tie
      if (mag_x > mag_z) begin
        flags_o.zero_dz = 1'b1;
      end else begin
        flags_o.zero_dx = 1'b1;
      end
    end else if (ok == KIND_NONE || ok == KIND_EDGE) begin
      flags_o = '{zero_dx: 1'b1, zero_dz: 1'b1};
    end else begin
      flags_o = axis_cancel(sc & oc);
    end
  end

endmodule

FILE: hw/rtl/box_slide_axis_blocker_unit.sv
// box slide axis blocker: input register, decision logic, result register
//
//   channel | handshake               | payload
//   in      | in_valid_i / in_ready_o | start_*, moved_*, obstacle_* (12 x s16)
//   out     | out_valid_o/out_ready_i | zero_dx_o, zero_dz_o
//
// one request per cycle sustained while out_ready_i stays high
// the decision is a single pass of compares and 17-bit adds between the
// input register and the result register
// rst_ni clears both valid flags asynchronously; payload registers are not reset
// a stall on the output holds the result register and then the input register,
// and ready drops only once both hold a request
module box_slide_axis_blocker_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsab_pkg::coord_t   start_x1_i,
  input  bsab_pkg::coord_t   start_x2_i,
  input  bsab_pkg::coord_t   start_z1_i,
  input  bsab_pkg::coord_t   start_z2_i,
  input  bsab_pkg::coord_t   moved_x1_i,
  input  bsab_pkg::coord_t   moved_x2_i,
  input  bsab_pkg::coord_t   moved_z1_i,
  input  bsab_pkg::coord_t   moved_z2_i,
  input  bsab_pkg::coord_t   obstacle_x1_i,
  input  bsab_pkg::coord_t   obstacle_x2_i,
  input  bsab_pkg::coord_t   obstacle_z1_i,
  input  bsab_pkg::coord_t   obstacle_z2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               zero_dx_o,
  output logic               zero_dz_o
);
  import bsab_pkg::*;

  `include "box_slide_axis_blocker_unit_assert.svh"

  boxes_t boxes_q;
  boxes_t boxes_d;
  logic   in_valid_q;
  logic   in_adv;
  logic   res_adv;
  flags_t flags_d;
  flags_t flags_q;
  logic   out_valid_q;

  assign boxes_d = '{
    start_x1:    start_x1_i,
    start_x2:    start_x2_i,
    start_z1:    start_z1_i,
    start_z2:    start_z2_i,
    moved_x1:    moved_x1_i,
    moved_x2:    moved_x2_i,
    moved_z1:    moved_z1_i,
    moved_z2:    moved_z2_i,
    obstacle_x1: obstacle_x1_i,
    obstacle_x2: obstacle_x2_i,
    obstacle_z1: obstacle_z1_i,
    obstacle_z2: obstacle_z2_i
  };

  // result register free when empty or being drained this cycle
  assign res_adv    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || res_adv;
  assign in_adv     = in_valid_i && in_ready_o;

  bsab_decide u_decide (
    .boxes_i (boxes_q),
    .flags_o (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (res_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      boxes_q <= boxes_d;
    end
    if (res_adv) begin
      flags_q <= flags_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign zero_dx_o   = flags_q.zero_dx;
  assign zero_dz_o   = flags_q.zero_dz;

  `BSAB_ASSERT_NEXT(a_accept_fills_input, in_adv, in_valid_q)
  `BSAB_ASSERT_NEXT(a_advance_fills_result, res_adv, out_valid_o)
  `BSAB_ASSERT_NEXT(a_drain_empties_result, out_valid_o && out_ready_i && !res_adv,
                    !out_valid_o)
  `BSAB_ASSERT_NEXT(a_blocked_input_holds, in_valid_q && !res_adv,
                    in_valid_q && $stable(boxes_q))

endmodule
